// ===== rtl/tcsr_pkg.sv =====
package tcsr_pkg;

    localparam int GLYPH_BANKS_DEF     = 12;
    localparam int MAX_COLS_DEF        = 80;
    localparam int MAX_CELL_HEIGHT_DEF = 16;

    localparam int OP_W       = 2;
    localparam int CODE_W     = 8;
    localparam int COL_W      = 7;
    localparam int ROW_W      = 6;
    localparam int GADDR_W    = 14;
    localparam int GDATA_W    = 8;
    localparam int PIX_W      = 6;
    localparam int SROW_W     = 4;
    localparam int HEIGHT_W   = 5;
    localparam int BANK_W     = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam int BANK_ROWS  = 1024;

    localparam logic [OP_W-1:0] OP_CELL  = 2'd0;
    localparam logic [OP_W-1:0] OP_GLYPH = 2'd1;
    localparam logic [OP_W-1:0] OP_FRAME = 2'd2;

    localparam logic [2:0] MODE_P   = 3'd0;
    localparam logic [2:0] MODE_A   = 3'd1;
    localparam logic [2:0] MODE_R   = 3'd2;
    localparam logic [2:0] MODE_M   = 3'd3;
    localparam logic [2:0] MODE_M80 = 3'd4;
    localparam logic [2:0] MODE_U   = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_MODE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_UL_ROW     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CURSOR_COL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CURSOR_ROW = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ALT_FONT   = 3'd5;

    localparam logic [BANK_W-1:0] BANK_FIXED = 4'd3;
    localparam logic [BANK_W-1:0] BANK_A     = 4'd8;
    localparam logic [BANK_W-1:0] BANK_A_ALT = 4'd9;
    localparam logic [BANK_W-1:0] BANK_M     = 4'd11;
    localparam logic [BANK_W-1:0] BANK_M_ALT = 4'd10;

    localparam logic [PIX_W-1:0] PIX_ALL = 6'h3f;

    typedef enum logic [2:0] {
        KIND_TEXT8,
        KIND_GLYPH,
        KIND_ATTR,
        KIND_BLANK,
        KIND_STRIPE
    } cell_kind_t;

    typedef struct packed {
        cell_kind_t          kind;
        logic [SROW_W-1:0]   last_k;
        logic [SROW_W-1:0]   h;
        logic                shift;
        logic [BANK_W-1:0]   bank;
        logic [6:0]          glyph_code;
        logic                addr_ok;
        logic [SROW_W-1:0]   ul_row;
        logic                ul_on;
        logic                cur;
        logic                andm;
        logic                xorm;
        logic                vis;
        logic                inv;
        logic                solid;
    } cell_desc_t;

    typedef struct packed {
        cell_desc_t          desc;
        logic [SROW_W-1:0]   k;
    } row_req_t;

endpackage

// ===== rtl/tcsr_if.sv =====
interface tcsr_cell_if import tcsr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    op;
    logic [CODE_W-1:0]  code;
    logic [COL_W-1:0]   col;
    logic [ROW_W-1:0]   row;
    logic               row_start;
    logic               attr_inverse;
    logic [GADDR_W-1:0] glyph_addr;
    logic [GDATA_W-1:0] glyph_data;

    modport source (output valid, op, code, col, row, row_start, attr_inverse,
                    glyph_addr, glyph_data, input ready);
    modport sink (input valid, op, code, col, row, row_start, attr_inverse,
                  glyph_addr, glyph_data, output ready);
endinterface

interface tcsr_pix_if import tcsr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [SROW_W-1:0] scan_row;
    logic [PIX_W-1:0]  pixels;
    logic              last_row;

    modport source (output valid, scan_row, pixels, last_row, input ready);
    modport sink (input valid, scan_row, pixels, last_row, output ready);
endinterface

interface tcsr_cfg_if import tcsr_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/text_cell_scanline_renderer.sv =====
// Text cell scanline renderer.
// cells: one beat per item. op CELL renders a character cell, op GLYPH writes
//   one glyph row into the glyph store, op FRAME ends the frame (advances the
//   blink count, clears attributes and blanking). Only CELL beats with a
//   column below MAX_COLS give output.
// pix: one beat per scan row of a cell, top row first, last_row on the final
//   one. A cell gives char_height rows (clamped 1..MAX_CELL_HEIGHT), or 8 in
//   the M80 and U modes.
// cfg: register writes, always ready; write only while the block is idle.
// Pipeline: each cell row passes the issue, read-data and output stages.
// Throughput: one scan row per cycle while pix is ready, set by the single
//   glyph store read port; the rows of a cell issue back to back and the
//   next cell follows without a gap. Non-cell beats give no rows.
// Stall: when pix is not ready the output, read-data and issue stages hold;
//   cells is taken again once the last row of the current cell has issued.
// Reset: flags, counters and registers return to defaults at once; glyph
//   store contents are undefined until written.
module text_cell_scanline_renderer import tcsr_pkg::*; #(
    parameter int GLYPH_BANKS     = GLYPH_BANKS_DEF,
    parameter int MAX_COLS        = MAX_COLS_DEF,
    parameter int MAX_CELL_HEIGHT = MAX_CELL_HEIGHT_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    tcsr_cell_if.sink  cells,
    tcsr_cfg_if.sink   cfg,
    tcsr_pix_if.source pix
);

    localparam int ADDR_W = $clog2(GLYPH_BANKS * BANK_ROWS);

    logic              b_free;
    logic              issue;
    row_req_t          issue_req;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [PIX_W-1:0]  wr_data;
    logic [ADDR_W-1:0] rd_addr;
    logic [PIX_W-1:0]  rd_data;

    tcsr_ctrl #(
        .GLYPH_BANKS     (GLYPH_BANKS),
        .MAX_COLS        (MAX_COLS),
        .MAX_CELL_HEIGHT (MAX_CELL_HEIGHT),
        .ADDR_W          (ADDR_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cells     (cells),
        .cfg       (cfg),
        .b_free    (b_free),
        .issue     (issue),
        .issue_req (issue_req),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr   (rd_addr)
    );

    tcsr_glyph_ram #(
        .GLYPH_BANKS (GLYPH_BANKS),
        .ADDR_W      (ADDR_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (issue),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    tcsr_shade u_shade (
        .clk       (clk),
        .rst_n     (rst_n),
        .issue     (issue),
        .issue_req (issue_req),
        .rd_data   (rd_data),
        .b_free    (b_free),
        .pix       (pix)
    );

endmodule

// ===== rtl/tcsr_glyph_ram.sv =====
module tcsr_glyph_ram import tcsr_pkg::*; #(
    parameter int GLYPH_BANKS = GLYPH_BANKS_DEF,
    parameter int ADDR_W = $clog2(GLYPH_BANKS * BANK_ROWS)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [PIX_W-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [PIX_W-1:0]  rd_data
);

    localparam int DEPTH = GLYPH_BANKS * BANK_ROWS;

    logic [PIX_W-1:0] glyph_mem [0:DEPTH-1];
    logic [PIX_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            glyph_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= glyph_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/tcsr_ctrl.sv =====
module tcsr_ctrl import tcsr_pkg::*; #(
    parameter int GLYPH_BANKS     = GLYPH_BANKS_DEF,
    parameter int MAX_COLS        = MAX_COLS_DEF,
    parameter int MAX_CELL_HEIGHT = MAX_CELL_HEIGHT_DEF,
    parameter int ADDR_W          = $clog2(GLYPH_BANKS * BANK_ROWS)
) (
    input  logic              clk,
    input  logic              rst_n,
    tcsr_cell_if.sink         cells,
    tcsr_cfg_if.sink          cfg,
    input  logic              b_free,
    output logic              issue,
    output row_req_t          issue_req,
    output logic              wr_en,
    output logic [ADDR_W-1:0] wr_addr,
    output logic [PIX_W-1:0]  wr_data,
    output logic [ADDR_W-1:0] rd_addr
);

    localparam int DEPTH = GLYPH_BANKS * BANK_ROWS;

    logic [2:0]          mode_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [SROW_W-1:0]   ul_row_reg;
    logic [COL_W-1:0]    cur_col_reg;
    logic [ROW_W-1:0]    cur_row_reg;
    logic                alt_reg;

    logic [4:0]          blink_cnt_reg, blink_cnt_next;
    logic                rev_reg, rev_next;
    logic                blink_reg, blink_next;
    logic                ul_on_reg, ul_on_next;
    logic [2:0]          bank_reg, bank_next;
    logic                scr_blank_reg, scr_blank_next;
    logic                row_blank_reg, row_blank_next;

    logic                a_valid_reg, a_valid_next;
    logic [SROW_W-1:0]   a_k_reg, a_k_next;
    cell_desc_t          a_desc_reg;

    logic                acc;
    logic                take_cell;
    logic                a_last;
    cell_desc_t          desc_new;
    logic                row_blank_eff;
    logic                mode8;
    logic [HEIGHT_W-1:0] hc;
    logic [COL_W:0]      ucol;
    logic [BANK_W-1:0]   cur_bank;
    logic                rev_upd;
    logic [SROW_W-1:0]   k_m1;
    logic [2:0]          r3;
    logic [GADDR_W-1:0]  rd_full;

    assign cfg.ready = 1'b1;

    assign a_last      = a_k_reg == a_desc_reg.last_k;
    assign issue       = a_valid_reg && b_free;
    assign cells.ready = !a_valid_reg || (b_free && a_last);
    assign acc         = cells.valid && cells.ready;

    assign k_m1    = a_k_reg - 4'd1;
    assign r3      = a_desc_reg.shift ? k_m1[2:0] : a_k_reg[2:0];
    assign rd_full = {a_desc_reg.bank, a_desc_reg.glyph_code, r3};
    assign rd_addr = rd_full[ADDR_W-1:0];

    assign issue_req.desc = a_desc_reg;
    assign issue_req.k    = a_k_reg;

    assign wr_en   = acc && (cells.op == OP_GLYPH)
                     && ({1'b0, cells.glyph_addr} < 15'(DEPTH));
    assign wr_addr = cells.glyph_addr[ADDR_W-1:0];
    assign wr_data = cells.glyph_data[PIX_W-1:0];

    always_comb
    begin
        take_cell = acc && (cells.op == OP_CELL) && ({1'b0, cells.col} < 8'(MAX_COLS));
        row_blank_eff = cells.row_start ? 1'b0 : row_blank_reg;
        mode8 = (mode_reg == MODE_M80) || (mode_reg == MODE_U);

        if (height_reg == '0)
        begin
            hc = 5'd1;
        end
        else if (height_reg > 5'(MAX_CELL_HEIGHT))
        begin
            hc = 5'(MAX_CELL_HEIGHT);
        end
        else
        begin
            hc = height_reg;
        end

        ucol = (mode_reg == MODE_P) ? ({1'b0, cells.col} + 8'd1) : {1'b0, cells.col};

        if (mode_reg == MODE_P)
        begin
            cur_bank = {1'b0, bank_reg};
        end
        else if (mode_reg == MODE_A)
        begin
            cur_bank = alt_reg ? BANK_A_ALT : BANK_A;
        end
        else if (mode_reg == MODE_M)
        begin
            cur_bank = alt_reg ? BANK_M_ALT : BANK_M;
        end
        else
        begin
            cur_bank = BANK_FIXED;
        end

        blink_cnt_next = blink_cnt_reg;
        rev_next       = rev_reg;
        blink_next     = blink_reg;
        ul_on_next     = ul_on_reg;
        bank_next      = bank_reg;
        scr_blank_next = scr_blank_reg;
        row_blank_next = row_blank_reg;

        rev_upd = rev_reg;

        desc_new.kind       = KIND_GLYPH;
        desc_new.last_k     = 4'(hc - 5'd1);
        desc_new.shift      = hc > 5'd8;
        desc_new.h          = (hc > 5'd8) ? 4'd9 : hc[SROW_W-1:0];
        desc_new.bank       = cur_bank;
        desc_new.glyph_code = cells.code[6:0];
        desc_new.addr_ok    = {1'b0, cur_bank} < 5'(GLYPH_BANKS);
        desc_new.ul_row     = ul_row_reg;
        desc_new.ul_on      = ul_on_reg;
        desc_new.cur        = (ucol == {1'b0, cur_col_reg}) && (cells.row == cur_row_reg)
                              && blink_cnt_reg[3];
        desc_new.andm       = !(blink_reg && !blink_cnt_reg[4]);
        desc_new.xorm       = rev_reg;
        desc_new.vis        = !(scr_blank_reg || row_blank_eff);
        desc_new.inv        = 1'b0;
        desc_new.solid      = 1'b0;

        if (mode8)
        begin
            desc_new.kind    = KIND_TEXT8;
            desc_new.last_k  = 4'd7;
            desc_new.shift   = 1'b0;
            desc_new.h       = 4'd8;
            desc_new.bank    = BANK_FIXED;
            desc_new.addr_ok = {1'b0, BANK_FIXED} < 5'(GLYPH_BANKS);
            desc_new.inv     = (mode_reg == MODE_U) ? cells.code[7] : cells.attr_inverse;
        end
        else if (!cells.code[7])
        begin
            desc_new.kind = KIND_GLYPH;
        end
        else if (!cells.code[6])
        begin
            desc_new.kind = KIND_ATTR;
            if (mode_reg == MODE_P)
            begin
                rev_upd = cells.code[4];
            end
            else if (mode_reg != MODE_M)
            begin
                rev_upd = cells.code[4];
            end
            desc_new.solid = rev_upd;
        end
        else if (cells.code[7:4] == 4'hf)
        begin
            desc_new.kind = KIND_BLANK;
        end
        else
        begin
            desc_new.kind  = KIND_STRIPE;
            desc_new.solid = !(cells.code[1] && !blink_cnt_reg[4])
                             && !(scr_blank_reg || row_blank_eff);
        end

        if (acc && (cells.op == OP_FRAME))
        begin
            blink_cnt_next = blink_cnt_reg + 5'd1;
            rev_next       = 1'b0;
            blink_next     = 1'b0;
            ul_on_next     = 1'b0;
            bank_next      = '0;
            scr_blank_next = 1'b0;
            row_blank_next = 1'b0;
        end
        else if (take_cell)
        begin
            row_blank_next = row_blank_eff;
            if (!mode8 && (desc_new.kind == KIND_ATTR))
            begin
                rev_next   = rev_upd;
                blink_next = cells.code[1];
                if (mode_reg == MODE_P)
                begin
                    bank_next  = {cells.code[0], cells.code[3], cells.code[2]};
                    ul_on_next = cells.code[5];
                end
            end
            else if (!mode8 && (desc_new.kind == KIND_BLANK))
            begin
                scr_blank_next = cells.code[1];
                row_blank_next = !cells.code[1];
            end
        end

        a_valid_next = a_valid_reg;
        a_k_next     = a_k_reg;
        if (take_cell)
        begin
            a_valid_next = 1'b1;
            a_k_next     = '0;
        end
        else if (issue)
        begin
            a_k_next = a_k_reg + 4'd1;
            if (a_last)
            begin
                a_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_P;
            height_reg    <= 5'd10;
            ul_row_reg    <= 4'd9;
            cur_col_reg   <= 7'd127;
            cur_row_reg   <= 6'd63;
            alt_reg       <= 1'b0;
            blink_cnt_reg <= '0;
            rev_reg       <= 1'b0;
            blink_reg     <= 1'b0;
            ul_on_reg     <= 1'b0;
            bank_reg      <= '0;
            scr_blank_reg <= 1'b0;
            row_blank_reg <= 1'b0;
            a_valid_reg   <= 1'b0;
            a_k_reg       <= '0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg.index)
                    REG_MODE:       mode_reg    <= cfg.data[2:0];
                    REG_HEIGHT:     height_reg  <= cfg.data[HEIGHT_W-1:0];
                    REG_UL_ROW:     ul_row_reg  <= cfg.data[SROW_W-1:0];
                    REG_CURSOR_COL: cur_col_reg <= cfg.data[COL_W-1:0];
                    REG_CURSOR_ROW: cur_row_reg <= cfg.data[ROW_W-1:0];
                    REG_ALT_FONT:   alt_reg     <= cfg.data[0];
                    default:        ;
                endcase
            end
            blink_cnt_reg <= blink_cnt_next;
            rev_reg       <= rev_next;
            blink_reg     <= blink_next;
            ul_on_reg     <= ul_on_next;
            bank_reg      <= bank_next;
            scr_blank_reg <= scr_blank_next;
            row_blank_reg <= row_blank_next;
            a_valid_reg   <= a_valid_next;
            a_k_reg       <= a_k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_cell)
        begin
            a_desc_reg <= desc_new;
        end
    end

endmodule

// ===== rtl/tcsr_shade.sv =====
module tcsr_shade import tcsr_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             issue,
    input  row_req_t         issue_req,
    input  logic [PIX_W-1:0] rd_data,
    output logic             b_free,
    tcsr_pix_if.source       pix
);

    logic              b_valid_reg;
    row_req_t          b_req_reg;
    logic              o_valid_reg;
    logic [SROW_W-1:0] o_row_reg;
    logic [PIX_W-1:0]  o_pix_reg;
    logic              o_last_reg;

    logic              adv_o;
    cell_desc_t        d;
    logic [SROW_W-1:0] k;
    logic [PIX_W-1:0]  g;
    logic [PIX_W-1:0]  b;
    logic [PIX_W-1:0]  px;
    logic              ul;

    assign adv_o  = !o_valid_reg || pix.ready;
    assign b_free = !b_valid_reg || adv_o;

    assign d = b_req_reg.desc;
    assign k = b_req_reg.k;

    always_comb
    begin
        g  = d.addr_ok ? rd_data : '0;
        ul = k == d.ul_row;
        b  = '0;
        px = '0;
        unique case (d.kind)
            KIND_TEXT8:
            begin
                px = g ^ {PIX_W{d.inv}};
            end
            KIND_GLYPH:
            begin
                if (k < d.h)
                begin
                    b = (d.shift && (k == '0)) ? '0 : g;
                    if (ul && d.ul_on)
                    begin
                        b = PIX_ALL;
                    end
                    if (ul && d.cur)
                    begin
                        b = b ^ PIX_ALL;
                    end
                    px = ((b & {PIX_W{d.andm}}) ^ {PIX_W{d.xorm}}) & {PIX_W{d.vis}};
                end
                else
                begin
                    b  = (ul && (d.ul_on || d.cur)) ? PIX_ALL : '0;
                    px = b ^ {PIX_W{d.xorm}};
                end
            end
            KIND_ATTR:
            begin
                px = (d.solid || (ul && d.cur)) ? PIX_ALL : '0;
            end
            KIND_BLANK:
            begin
                px = '0;
            end
            KIND_STRIPE:
            begin
                px = ((k < d.h) && !k[0]) ? {PIX_W{d.solid}} : '0;
            end
            default:
            begin
                px = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (b_free)
            begin
                b_valid_reg <= issue;
            end
            if (adv_o)
            begin
                o_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_free && issue)
        begin
            b_req_reg <= issue_req;
        end
        if (adv_o && b_valid_reg)
        begin
            o_row_reg  <= k;
            o_pix_reg  <= px;
            o_last_reg <= k == d.last_k;
        end
    end

    assign pix.valid    = o_valid_reg;
    assign pix.scan_row = o_row_reg;
    assign pix.pixels   = o_pix_reg;
    assign pix.last_row = o_last_reg;

endmodule

// ===== sim/text_cell_scanline_renderer_tb.sv =====
`timescale 1ns / 1ps

module text_cell_scanline_renderer_tb;
    import tcsr_pkg::*;

    localparam int STORE_DEPTH   = GLYPH_BANKS_DEF * BANK_ROWS;
    localparam int MAX_H         = MAX_CELL_HEIGHT_DEF;
    localparam int SETTLE_CYCLES = 8;
    localparam int LIMIT_CYCLES  = 1000000;

    localparam logic [OP_W-1:0] OP_NONE = 2'd3;

    localparam logic [CODE_W-1:0] CODE_ATTR    = 8'h80;
    localparam logic [CODE_W-1:0] CODE_STRIPE  = 8'hC0;
    localparam logic [CODE_W-1:0] CODE_BLANK   = 8'hF0;
    localparam logic [CODE_W-1:0] ATTR_NONE    = 8'h80;
    localparam logic [CODE_W-1:0] ATTR_REVERSE = 8'h90;
    localparam logic [CODE_W-1:0] ATTR_UL      = 8'hA0;
    localparam logic [CODE_W-1:0] ATTR_REV_BLK = 8'h92;
    localparam logic [CODE_W-1:0] ATTR_ALL     = 8'hBF;
    localparam logic [CODE_W-1:0] STRIPE_PLAIN = 8'hC0;
    localparam logic [CODE_W-1:0] STRIPE_BLINK = 8'hEF;
    localparam logic [CODE_W-1:0] BLANK_ROW    = 8'hF0;
    localparam logic [CODE_W-1:0] BLANK_SCREEN = 8'hF2;
    localparam logic [CODE_W-1:0] BLANK_TOP    = 8'hFF;

    localparam logic [6:0] POOL_LO = 7'h15;
    localparam logic [6:0] POOL_HI = 7'h6A;

    typedef struct {
        logic [OP_W-1:0]    op;
        logic [CODE_W-1:0]  code;
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   row;
        logic               row_start;
        logic               attr_inverse;
        logic [GADDR_W-1:0] glyph_addr;
        logic [GDATA_W-1:0] glyph_data;
    } cell_item_t;

    typedef struct {
        logic [SROW_W-1:0] scan_row;
        logic [PIX_W-1:0]  pixels;
        logic              last_row;
    } scan_slice_t;

    logic clk = 1'b0;
    logic rst_n;

    tcsr_cell_if cell_bus ();
    tcsr_cfg_if  cfg_bus ();
    tcsr_pix_if  pix_bus ();

    text_cell_scanline_renderer dut (clk, rst_n, cell_bus, cfg_bus, pix_bus);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // renderer state as predicted
    logic [GDATA_W-1:0] glyph_mem [STORE_DEPTH];
    logic [4:0]         blink_ctr    = '0;
    logic               rev_flag     = 1'b0;
    logic               blink_flag   = 1'b0;
    logic               ul_flag      = 1'b0;
    logic [BANK_W-1:0]  bank_sel     = '0;
    logic               scr_blank    = 1'b0;
    logic               line_blank   = 1'b0;
    logic [2:0]         mode_reg     = MODE_P;
    logic [4:0]         height_reg   = 5'd10;
    logic [3:0]         ul_row_reg   = 4'd9;
    logic [6:0]         cur_col_reg  = 7'd127;
    logic [5:0]         cur_row_reg  = 6'd63;
    logic               alt_font_reg = 1'b0;

    scan_slice_t expected_slices[$];

    int mismatch_count  = 0;
    int cycle_count     = 0;
    int hold_off_cycles = 0;
    int burst_left      = 0;
    bit gaps_on         = 1'b1;

    function automatic logic [PIX_W-1:0] glyph_slice(logic [BANK_W-1:0] bank,
                                                      logic [CODE_W-1:0] code, int r);
        int addr;
        addr = int'(bank) * BANK_ROWS + int'(code[6:0]) * 8 + r;
        return (addr < STORE_DEPTH) ? glyph_mem[addr][PIX_W-1:0] : '0;
    endfunction

    function automatic void render_expected(cell_item_t it);
        logic [PIX_W-1:0]  rows [MAX_H];
        int                height, h, ucol, k;
        logic              cur_here, shift;
        logic [PIX_W-1:0]  andm, xorm, vis, b, v;
        logic [BANK_W-1:0] bank;
        scan_slice_t       s;
        if (it.op == OP_GLYPH)
        begin
            if (it.glyph_addr < STORE_DEPTH)
                glyph_mem[it.glyph_addr] = it.glyph_data;
            return;
        end
        if (it.op == OP_FRAME)
        begin
            blink_ctr  = blink_ctr + 5'd1;
            rev_flag   = 1'b0;
            blink_flag = 1'b0;
            ul_flag    = 1'b0;
            bank_sel   = '0;
            scr_blank  = 1'b0;
            line_blank = 1'b0;
            return;
        end
        if (it.op != OP_CELL || it.col >= MAX_COLS_DEF)
            return;

        if (it.row_start)
            line_blank = 1'b0;
        for (k = 0; k < MAX_H; k++)
            rows[k] = '0;

        if (mode_reg == MODE_M80 || mode_reg == MODE_U)
        begin
            height = 8;
            for (k = 0; k < height; k++)
            begin
                b = glyph_slice(BANK_FIXED, it.code, k);
                if ((mode_reg == MODE_U && it.code[7]) || (mode_reg == MODE_M80 && it.attr_inverse))
                    b = ~b;
                rows[k] = b;
            end
        end
        else
        begin
            ucol = (mode_reg == MODE_P) ? int'(it.col) + 1 : int'(it.col);
            cur_here = (ucol == cur_col_reg) && (it.row == cur_row_reg) && blink_ctr[3];
            height = (height_reg == 0) ? 1 : ((height_reg > MAX_H) ? MAX_H : int'(height_reg));
            shift = (height > 8);
            h = shift ? 9 : height;

            if (it.code < CODE_ATTR)
            begin
                andm = (blink_flag && !blink_ctr[4]) ? '0 : PIX_ALL;
                xorm = rev_flag ? PIX_ALL : '0;
                vis  = (scr_blank || line_blank) ? '0 : PIX_ALL;
                case (mode_reg)
                    MODE_P:  bank = bank_sel;
                    MODE_A:  bank = alt_font_reg ? BANK_A_ALT : BANK_A;
                    MODE_M:  bank = alt_font_reg ? BANK_M_ALT : BANK_M;
                    default: bank = BANK_FIXED;
                endcase
                for (k = 0; k < height; k++)
                begin
                    if (k < h)
                    begin
                        if (shift)
                            b = (k == 0) ? '0 : glyph_slice(bank, it.code, k - 1);
                        else
                            b = glyph_slice(bank, it.code, k);
                        if (k == ul_row_reg && ul_flag)
                            b = PIX_ALL;
                        if (k == ul_row_reg && cur_here)
                            b = ~b;
                        b = ((b & andm) ^ xorm) & vis;
                    end
                    else
                    begin
                        // padding below a shifted glyph ignores blanking and blink
                        b = (k == ul_row_reg && (ul_flag || cur_here)) ? PIX_ALL : '0;
                        b = b ^ xorm;
                    end
                    rows[k] = b;
                end
            end
            else if (it.code < CODE_STRIPE)
            begin
                if (mode_reg == MODE_P)
                begin
                    bank_sel   = {1'b0, it.code[0], it.code[3], it.code[2]};
                    rev_flag   = it.code[4];
                    blink_flag = it.code[1];
                    ul_flag    = it.code[5];
                end
                else if (mode_reg == MODE_M)
                    blink_flag = it.code[1];
                else
                begin
                    rev_flag   = it.code[4];
                    blink_flag = it.code[1];
                end
                for (k = 0; k < height; k++)
                    if (rev_flag || (k == ul_row_reg && cur_here))
                        rows[k] = PIX_ALL;
            end
            else if (it.code >= CODE_BLANK)
            begin
                scr_blank  = it.code[1];
                line_blank = !it.code[1];
            end
            else
            begin
                v = (it.code[1] && !blink_ctr[4]) ? '0 : PIX_ALL;
                if (scr_blank || line_blank)
                    v = '0;
                for (k = 0; k < h; k += 2)
                    rows[k] = v;
            end
        end

        for (k = 0; k < height; k++)
        begin
            s.scan_row = SROW_W'(k);
            s.pixels   = rows[k];
            s.last_row = (k + 1 == height);
            expected_slices.push_back(s);
        end
    endfunction

    function automatic cell_item_t noisy_item(logic [OP_W-1:0] op);
        cell_item_t it;
        it.op           = op;
        it.code         = CODE_W'($urandom);
        it.col          = COL_W'($urandom);
        it.row          = ROW_W'($urandom);
        it.row_start    = 1'($urandom);
        it.attr_inverse = 1'($urandom);
        it.glyph_addr   = GADDR_W'($urandom);
        it.glyph_data   = GDATA_W'($urandom);
        return it;
    endfunction

    // keep every glyph lookup on the loaded codes
    function automatic logic [CODE_W-1:0] pooled_code(logic [CODE_W-1:0] code);
        if (!code[7] || mode_reg == MODE_M80 || mode_reg == MODE_U)
            return {code[7], code[0] ? POOL_HI : POOL_LO};
        return code;
    endfunction

    function automatic cell_item_t cell_at(logic [CODE_W-1:0] code, int col, int row, bit first);
        cell_item_t it;
        it           = noisy_item(OP_CELL);
        it.code      = pooled_code(code);
        it.col       = COL_W'(col);
        it.row       = ROW_W'(row);
        it.row_start = first;
        return it;
    endfunction

    task automatic report_mismatch(string what);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("mismatch at %0t: %s", $time, what);
    endtask

    task automatic send_beat(cell_item_t it);
        if (gaps_on && burst_left == 0)
        begin
            cell_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
        if (burst_left > 0)
            burst_left--;
        cell_bus.valid        <= 1'b1;
        cell_bus.op           <= it.op;
        cell_bus.code         <= it.code;
        cell_bus.col          <= it.col;
        cell_bus.row          <= it.row;
        cell_bus.row_start    <= it.row_start;
        cell_bus.attr_inverse <= it.attr_inverse;
        cell_bus.glyph_addr   <= it.glyph_addr;
        cell_bus.glyph_data   <= it.glyph_data;
        do
            @(posedge clk);
        while (!cell_bus.ready);
        render_expected(it);
    endtask

    task automatic drain_results();
        cell_bus.valid <= 1'b0;
        while (expected_slices.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_regs(logic [2:0] mode, logic [4:0] height, logic [3:0] ul,
                                logic [6:0] ccol, logic [5:0] crow, logic alt);
        logic [CFG_IDX_W-1:0]  ids [6];
        logic [CFG_DATA_W-1:0] vals [6];
        int                    i;
        ids  = '{REG_MODE, REG_HEIGHT, REG_UL_ROW, REG_CURSOR_COL, REG_CURSOR_ROW, REG_ALT_FONT};
        vals = '{CFG_DATA_W'(mode), CFG_DATA_W'(height), CFG_DATA_W'(ul),
                 CFG_DATA_W'(ccol), CFG_DATA_W'(crow), CFG_DATA_W'(alt)};
        for (i = 0; i < 6; i++)
        begin
            cfg_bus.valid <= 1'b1;
            cfg_bus.index <= ids[i];
            cfg_bus.data  <= vals[i];
            do
                @(posedge clk);
            while (!cfg_bus.ready);
            case (ids[i])
                REG_MODE:       mode_reg     = vals[i][2:0];
                REG_HEIGHT:     height_reg   = vals[i][4:0];
                REG_UL_ROW:     ul_row_reg   = vals[i][3:0];
                REG_CURSOR_COL: cur_col_reg  = vals[i][6:0];
                REG_CURSOR_ROW: cur_row_reg  = vals[i][5:0];
                REG_ALT_FONT:   alt_font_reg = vals[i][0];
                default: ;
            endcase
        end
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic test_store_load();
        cell_item_t it;
        int         bk, p, r;
        logic [6:0] pc;
        // load the pooled codes in every bank
        for (bk = 0; bk < GLYPH_BANKS_DEF; bk++)
        begin
            for (p = 0; p < 2; p++)
            begin
                pc = (p == 0) ? POOL_LO : POOL_HI;
                for (r = 0; r < 8; r++)
                begin
                    it = noisy_item(OP_GLYPH);
                    it.glyph_addr = GADDR_W'(bk * BANK_ROWS + int'(pc) * 8 + r);
                    send_beat(it);
                end
            end
        end
        // writes past the store are dropped
        it = noisy_item(OP_GLYPH);
        it.glyph_addr = GADDR_W'(STORE_DEPTH);
        send_beat(it);
        it.glyph_addr = '1;
        send_beat(it);
        send_beat(noisy_item(OP_NONE));
        drain_results();
    endtask

    task automatic test_directed();
        send_beat(cell_at(8'h00, 0, 0, 1'b1));
        send_beat(cell_at(8'h7F, MAX_COLS_DEF - 1, 63, 1'b0));
        send_beat(cell_at(8'h55, MAX_COLS_DEF, 1, 1'b0));
        send_beat(cell_at(8'h2A, 127, 63, 1'b1));
        send_beat(noisy_item(OP_NONE));
        send_beat(cell_at(ATTR_ALL, 1, 0, 1'b0));
        send_beat(cell_at(8'h41, 2, 0, 1'b0));
        send_beat(cell_at(ATTR_NONE, 3, 0, 1'b0));
        send_beat(cell_at(8'h3C, 4, 0, 1'b0));
        send_beat(cell_at(STRIPE_PLAIN, 5, 0, 1'b0));
        send_beat(cell_at(STRIPE_BLINK, 6, 0, 1'b0));
        send_beat(cell_at(BLANK_ROW, 7, 0, 1'b0));
        send_beat(cell_at(8'h20, 8, 0, 1'b0));
        send_beat(cell_at(STRIPE_PLAIN, 9, 0, 1'b0));
        send_beat(cell_at(8'h30, 0, 1, 1'b1));
        send_beat(cell_at(BLANK_SCREEN, 1, 1, 1'b0));
        send_beat(cell_at(8'h7E, 0, 2, 1'b1));
        send_beat(cell_at(ATTR_REVERSE, 1, 2, 1'b0));
        send_beat(cell_at(8'h01, 2, 2, 1'b0));
        send_beat(noisy_item(OP_FRAME));
        send_beat(cell_at(8'h01, 0, 0, 1'b1));
        send_beat(cell_at(BLANK_TOP, 1, 0, 1'b0));
        send_beat(noisy_item(OP_FRAME));
        drain_results();
    endtask

    task automatic test_cursor_underline();
        logic [2:0] modes [4];
        logic [4:0] heights [4];
        logic [3:0] uls [4];
        int         c, ccol;
        modes   = '{MODE_P, MODE_A, MODE_M, MODE_R};
        heights = '{5'd16, 5'd9, 5'd8, 5'd12};
        uls     = '{4'd12, 4'd8, 4'd7, 4'd3};
        // advance the blink count into the cursor-on half
        while (!blink_ctr[3])
            send_beat(noisy_item(OP_FRAME));
        for (c = 0; c < 4; c++)
        begin
            drain_results();
            program_regs(modes[c], heights[c], uls[c], 7'd6, 6'd2, 1'(c % 2));
            ccol = (modes[c] == MODE_P) ? 5 : 6;
            send_beat(cell_at(8'h15, ccol, 2, 1'b1));
            send_beat(cell_at(ATTR_UL, ccol - 1, 2, 1'b0));
            send_beat(cell_at(8'h15, ccol, 2, 1'b0));
            send_beat(cell_at(ATTR_REV_BLK, ccol, 2, 1'b0));
            send_beat(cell_at(STRIPE_PLAIN, ccol, 2, 1'b0));
            send_beat(cell_at(8'h15, ccol + 1, 2, 1'b0));
        end
        drain_results();
    endtask

    task automatic test_output_stall();
        int n;
        program_regs(MODE_P, 5'd16, 4'd15, 7'd127, 6'd63, 1'b0);
        hold_off_cycles = 300;
        gaps_on = 1'b0;
        for (n = 0; n < 30; n++)
            send_beat(cell_at(CODE_W'($urandom_range(0, 127)), n, 5, n == 0));
        gaps_on = 1'b1;
        // hold the sender until every row is back
        drain_results();
    endtask

    task automatic test_random_phases();
        cell_item_t it;
        int         ph, n, pick, line_len, pos_col, pos_row, k, frames;
        logic [2:0] mode;
        logic [4:0] height;
        logic [3:0] ul;
        logic [6:0] ccol;
        logic [5:0] crow;
        for (ph = 0; ph < 12; ph++)
        begin
            drain_results();
            mode = (ph < 8) ? 3'(ph) : 3'($urandom_range(0, 5));
            case (ph % 6)
                0:       height = 5'd1;
                1:       height = 5'd16;
                2:       height = 5'd8;
                3:       height = 5'd9;
                4:       height = (ph < 6) ? 5'd0 : 5'd31;
                default: height = 5'($urandom_range(2, 15));
            endcase
            case (ph % 3)
                0:       ul = 4'd0;
                1:       ul = 4'd15;
                default: ul = 4'($urandom_range(0, 15));
            endcase
            line_len = ($urandom_range(0, 4) == 0) ? MAX_COLS_DEF : $urandom_range(4, 12);
            crow = 6'($urandom_range(0, 63));
            ccol = 7'($urandom_range(0, line_len));
            program_regs(mode, height, ul, ccol, crow, 1'($urandom));
            pos_col = 0;
            pos_row = crow;
            for (n = 0; n < 14; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 5)
                begin
                    it = noisy_item(OP_GLYPH);
                    it.glyph_addr = GADDR_W'($urandom_range(0, STORE_DEPTH - 1));
                    send_beat(it);
                end
                else if (pick < 12)
                begin
                    frames = (pick == 5) ? $urandom_range(4, 12) : 1;
                    for (k = 0; k < frames; k++)
                        send_beat(noisy_item(OP_FRAME));
                    pos_col = 0;
                    pos_row = crow;
                end
                else if (pick < 15)
                begin
                    it = noisy_item((pick == 12) ? OP_NONE : OP_CELL);
                    if (pick != 12)
                        it.col = COL_W'($urandom_range(MAX_COLS_DEF, 127));
                    send_beat(it);
                end
                else
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 50)
                        it = cell_at(CODE_W'($urandom_range(0, 127)), pos_col, pos_row, pos_col == 0);
                    else if (pick < 68)
                        it = cell_at(CODE_W'($urandom_range(CODE_ATTR, CODE_STRIPE - 1)),
                                     pos_col, pos_row, pos_col == 0);
                    else if (pick < 80)
                        it = cell_at(CODE_W'($urandom_range(CODE_STRIPE, CODE_BLANK - 1)),
                                     pos_col, pos_row, pos_col == 0);
                    else if (pick < 88)
                        it = cell_at(CODE_W'($urandom_range(CODE_BLANK, 255)),
                                     pos_col, pos_row, pos_col == 0);
                    else
                        it = cell_at(CODE_W'($urandom), pos_col, pos_row, pos_col == 0);
                    send_beat(it);
                    pos_col++;
                    if (pos_col >= line_len)
                    begin
                        pos_col = 0;
                        pos_row = (pos_row + 1) % 64;
                    end
                end
            end
        end
        drain_results();
    endtask

    always @(posedge clk)
    begin : slice_check
        scan_slice_t want;
        if (rst_n && pix_bus.valid && pix_bus.ready)
        begin
            if (expected_slices.size() == 0)
                report_mismatch($sformatf("unexpected beat: scan_row %0d pixels %h",
                                          pix_bus.scan_row, pix_bus.pixels));
            else
            begin
                want = expected_slices.pop_front();
                if (pix_bus.scan_row !== want.scan_row)
                    report_mismatch($sformatf("scan_row %0d, expected %0d",
                                              pix_bus.scan_row, want.scan_row));
                if (pix_bus.pixels !== want.pixels)
                    report_mismatch($sformatf("pixels %h, expected %h on scan_row %0d",
                                              pix_bus.pixels, want.pixels, want.scan_row));
                if (pix_bus.last_row !== want.last_row)
                    report_mismatch($sformatf("last_row %b, expected %b on scan_row %0d",
                                              pix_bus.last_row, want.last_row, want.scan_row));
            end
        end
    end

    initial
    begin : sink_side
        int style, style_left;
        style = 0;
        style_left = 0;
        pix_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (style_left == 0)
            begin
                style = $urandom_range(0, 3);
                style_left = $urandom_range(20, 120);
            end
            style_left--;
            if (hold_off_cycles > 0)
            begin
                hold_off_cycles--;
                pix_bus.ready <= 1'b0;
            end
            else
            begin
                case (style)
                    0:       pix_bus.ready <= 1'b1;
                    1:       pix_bus.ready <= ($urandom_range(0, 3) != 0);
                    2:       pix_bus.ready <= ~pix_bus.ready;
                    default: pix_bus.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("text_cell_scanline_renderer_tb: FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n                 <= 1'b0;
        cell_bus.valid        <= 1'b0;
        cell_bus.op           <= OP_CELL;
        cell_bus.code         <= '0;
        cell_bus.col          <= '0;
        cell_bus.row          <= '0;
        cell_bus.row_start    <= 1'b0;
        cell_bus.attr_inverse <= 1'b0;
        cell_bus.glyph_addr   <= '0;
        cell_bus.glyph_data   <= '0;
        cfg_bus.valid         <= 1'b0;
        cfg_bus.index         <= REG_MODE;
        cfg_bus.data          <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_store_load();
        test_directed();
        test_cursor_underline();
        test_output_stall();
        test_random_phases();

        drain_results();
        repeat (16) @(posedge clk);
        if (mismatch_count == 0)
            $display("text_cell_scanline_renderer_tb: PASS");
        else
            $display("text_cell_scanline_renderer_tb: FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/tcsr_pkg.sv
rtl/tcsr_if.sv
rtl/tcsr_glyph_ram.sv
rtl/tcsr_ctrl.sv
rtl/tcsr_shade.sv
rtl/text_cell_scanline_renderer.sv
sim/text_cell_scanline_renderer_tb.sv
